// ----- hw/rtl/sdtq_pkg.sv -----
package sdtq_pkg;

  // default sizes of the queue
  localparam int DEPTH_DEF     = 16;
  localparam int TIME_BITS_DEF = 32;

  // fixed field widths
  localparam int ID_W     = 8;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 3;

  // most timers popped by one wake or flush word
  localparam int MAX_POPS = 16;

  // operation codes of the input word
  typedef enum logic [OP_W-1:0] {
    OP_START  = 2'd0,
    OP_CANCEL = 2'd1,
    OP_WAKE   = 2'd2,
    OP_FLUSH  = 2'd3
  } op_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_STARTED   = 3'd0,
    STAT_FULL      = 3'd1,
    STAT_CANCELLED = 3'd2,
    STAT_ABSENT    = 3'd3,
    STAT_EXPIRED   = 3'd4,
    STAT_NONE      = 3'd5
  } status_t;

  // sequencer states, one-hot
  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_SCAN     = 8'b0000_0010,
    ST_DECIDE   = 8'b0000_0100,
    ST_EMIT_PRE = 8'b0000_1000,
    ST_EMIT     = 8'b0001_0000,
    ST_MOVE     = 8'b0010_0000,
    ST_INSERT   = 8'b0100_0000,
    ST_RESULT   = 8'b1000_0000
  } state_t;

endpackage

// ----- hw/rtl/sorted_deadline_timer_queue.sv -----
// flow: start and cancel scan the queued timers, move slots, then answer; wake and
//   flush scan, then give their expired ids one per cycle while the output does not stall
// throughput: one word at a time, each also held by result stalls: a scan
//   pass over the single slot ram, then a pass that moves slots
// reset: synchronous, clears the queue count, sequencer and output valid; slot ram
//   contents are left as they are and need no clearing pass
module sorted_deadline_timer_queue
  import sdtq_pkg::*;
#(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [OP_W-1:0]      in_op,
  input  logic [ID_W-1:0]      in_timer_id,
  input  logic [TIME_BITS-1:0] in_duration,
  input  logic [TIME_BITS-1:0] in_now_time,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [STATUS_W-1:0]  out_status,
  output logic [ID_W-1:0]      out_expired_id,
  output logic                 out_last
);

  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int ENT_W   = 2 * TIME_BITS + ID_W;
  localparam int POP_CAP = (DEPTH < MAX_POPS) ? DEPTH : MAX_POPS;
  localparam logic [CNT_W-1:0] DEPTH_C   = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] POP_CAP_C = CNT_W'(POP_CAP);
  localparam logic [CNT_W-1:0] ONE_C     = CNT_W'(1);

  // sequencer and queue state
  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  // word under work
  op_t                op_r;
  logic [ID_W-1:0]    id_r;
  logic [TIME_BITS-1:0] dur_r, now_r;

  // scan pipeline
  logic [CNT_W-1:0]   scan_idx_r, scan_idx_nxt;
  logic               s1_v_r, s2_v_r;
  logic [CNT_W-1:0]   s1_idx_r, s2_idx_r;
  logic [TIME_BITS-1:0] el_r, s2_dur_r;
  logic               s2_match_r;

  // scan findings
  logic               found_r, found_nxt;
  logic [CNT_W-1:0]   pos_r, pos_nxt;
  logic               at_found_r, at_found_nxt;
  logic [CNT_W-1:0]   at_r, at_nxt;
  logic               pop_stop_r, pop_stop_nxt;
  logic [CNT_W-1:0]   k_r, k_nxt;

  // slot move sweep and insert
  logic [CNT_W-1:0]   mv_src_r, mv_src_nxt;
  logic [CNT_W-1:0]   mv_left_r, mv_left_nxt;
  logic               mv_up_r, mv_up_nxt;
  logic [CNT_W-1:0]   mv_shift_r, mv_shift_nxt;
  logic               mv_pend_r, mv_pend_nxt;
  logic [CNT_W-1:0]   mv_dst_r, mv_dst_nxt;
  logic               ins_en_r, ins_en_nxt;
  logic [CNT_W-1:0]   ins_r, ins_nxt;

  // single result and pop emission
  logic               res_en_r, res_en_nxt;
  status_t            res_status_r, res_status_nxt;
  logic [ID_W-1:0]    res_id_r, res_id_nxt;
  logic [CNT_W-1:0]   emit_idx_r, emit_idx_nxt;

  // output register
  logic               out_valid_r;
  status_t            out_status_r;
  logic [ID_W-1:0]    out_id_r;
  logic               out_last_r;
  logic               out_free, out_load;
  status_t            load_status;
  logic [ID_W-1:0]    load_id;
  logic               load_last;

  // ram ports
  logic               ram_we;
  logic [CNT_W-1:0]   ram_waddr;
  logic [ENT_W-1:0]   ram_wdata;
  logic [CNT_W-1:0]   ram_raddr;
  logic [ENT_W-1:0]   ram_rdata;

  // misc decode
  logic               in_fire, scan_issue, scan_last;
  logic [TIME_BITS-1:0] rd_start, rd_dur;
  logic [ID_W-1:0]    rd_id;
  logic [TIME_BITS:0] dl_sum;
  logic               is_after, is_exp;
  logic [CNT_W-1:0]   at_val;

  sdtq_ram #(
    .WIDTH (ENT_W),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr[IDX_W-1:0]),
    .wdata (ram_wdata),
    .raddr (ram_raddr[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  // slot word fields: start time, duration, id
  assign rd_start = ram_rdata[ENT_W-1 -: TIME_BITS];
  assign rd_dur   = ram_rdata[ID_W +: TIME_BITS];
  assign rd_id    = ram_rdata[ID_W-1:0];

  assign in_stall = (state_r != ST_IDLE);
  assign in_fire  = in_valid && (state_r == ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  // scan control
  assign scan_issue = (state_r == ST_SCAN) && (scan_idx_r < count_r);
  assign scan_last  = s2_v_r && (s2_idx_r == count_r - ONE_C);

  // deadline compare on the registered elapsed time
  assign dl_sum   = {1'b0, dur_r} + {1'b0, el_r};
  assign is_after = !dl_sum[TIME_BITS] && (s2_dur_r > dl_sum[TIME_BITS-1:0]);
  assign is_exp   = (op_r == OP_FLUSH) || (el_r >= s2_dur_r);
  assign at_val   = at_found_r ? at_r : count_r;

  // write port: sweep moves first, then the new slot
  assign ram_we    = mv_pend_r || (state_r == ST_INSERT);
  assign ram_waddr = mv_pend_r ? mv_dst_r : ins_r;
  assign ram_wdata = mv_pend_r ? ram_rdata : {now_r, dur_r, id_r};

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    scan_idx_nxt   = scan_idx_r;
    found_nxt      = found_r;
    pos_nxt        = pos_r;
    at_found_nxt   = at_found_r;
    at_nxt         = at_r;
    pop_stop_nxt   = pop_stop_r;
    k_nxt          = k_r;
    mv_src_nxt     = mv_src_r;
    mv_left_nxt    = mv_left_r;
    mv_up_nxt      = mv_up_r;
    mv_shift_nxt   = mv_shift_r;
    mv_pend_nxt    = 1'b0;
    mv_dst_nxt     = mv_dst_r;
    ins_en_nxt     = ins_en_r;
    ins_nxt        = ins_r;
    res_en_nxt     = res_en_r;
    res_status_nxt = res_status_r;
    res_id_nxt     = res_id_r;
    emit_idx_nxt   = emit_idx_r;
    ram_raddr      = scan_idx_r;
    out_load       = 1'b0;
    load_status    = res_status_r;
    load_id        = res_id_r;
    load_last      = 1'b1;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          scan_idx_nxt = '0;
          found_nxt    = 1'b0;
          at_found_nxt = 1'b0;
          pop_stop_nxt = 1'b0;
          k_nxt        = '0;
          state_nxt    = (count_r != '0) ? ST_SCAN : ST_DECIDE;
        end
      end

      ST_SCAN: begin
        ram_raddr = scan_idx_r;
        if (scan_issue) begin
          scan_idx_nxt = scan_idx_r + ONE_C;
        end
        if (s2_v_r) begin
          // first id match, then first slot that expires after the new timer
          if (s2_match_r && !found_r) begin
            found_nxt = 1'b1;
            pos_nxt   = s2_idx_r;
          end else if (is_after && !at_found_r) begin
            at_found_nxt = 1'b1;
            at_nxt       = s2_idx_r;
          end
          // count expired head slots, stop at the first live one or the cap
          if (!pop_stop_r) begin
            if (is_exp && (k_r < POP_CAP_C)) begin
              k_nxt = k_r + ONE_C;
            end else begin
              pop_stop_nxt = 1'b1;
            end
          end
          if (scan_last) begin
            state_nxt = ST_DECIDE;
          end
        end
      end

      ST_DECIDE: begin
        mv_left_nxt  = '0;
        mv_up_nxt    = 1'b0;
        mv_shift_nxt = ONE_C;
        ins_en_nxt   = 1'b0;
        res_en_nxt   = 1'b1;
        res_id_nxt   = id_r;
        emit_idx_nxt = '0;
        state_nxt    = ST_MOVE;
        unique case (op_r)
          OP_START: begin
            if (!found_r && (count_r == DEPTH_C)) begin
              res_status_nxt = STAT_FULL;
            end else begin
              res_status_nxt = STAT_STARTED;
              ins_en_nxt     = 1'b1;
              if (!found_r) begin
                // open a gap at the insert point
                mv_up_nxt   = 1'b1;
                mv_src_nxt  = count_r - ONE_C;
                mv_left_nxt = count_r - at_val;
                ins_nxt     = at_val;
                count_nxt   = count_r + ONE_C;
              end else if (pos_r < at_val) begin
                // restart moving later: close up toward the old slot
                mv_src_nxt  = pos_r + ONE_C;
                mv_left_nxt = at_val - ONE_C - pos_r;
                ins_nxt     = at_val - ONE_C;
              end else begin
                // restart moving earlier: push slots toward the old slot
                mv_up_nxt   = 1'b1;
                mv_src_nxt  = pos_r - ONE_C;
                mv_left_nxt = pos_r - at_val;
                ins_nxt     = at_val;
              end
            end
          end
          OP_CANCEL: begin
            if (found_r) begin
              res_status_nxt = STAT_CANCELLED;
              mv_src_nxt     = pos_r + ONE_C;
              mv_left_nxt    = count_r - ONE_C - pos_r;
              count_nxt      = count_r - ONE_C;
            end else begin
              res_status_nxt = STAT_ABSENT;
            end
          end
          OP_WAKE, OP_FLUSH: begin
            if (k_r == '0) begin
              res_status_nxt = STAT_NONE;
              res_id_nxt     = '0;
            end else begin
              // emit popped ids, then slide the rest down by k
              res_en_nxt   = 1'b0;
              mv_src_nxt   = k_r;
              mv_left_nxt  = count_r - k_r;
              mv_shift_nxt = k_r;
              count_nxt    = count_r - k_r;
              state_nxt    = ST_EMIT_PRE;
            end
          end
          default: begin
            res_status_nxt = STAT_NONE;
          end
        endcase
      end

      ST_EMIT_PRE: begin
        ram_raddr = '0;
        state_nxt = ST_EMIT;
      end

      ST_EMIT: begin
        load_status = STAT_EXPIRED;
        load_id     = rd_id;
        load_last   = (emit_idx_r == k_r - ONE_C);
        ram_raddr   = emit_idx_r;
        if (out_free) begin
          out_load     = 1'b1;
          emit_idx_nxt = emit_idx_r + ONE_C;
          ram_raddr    = emit_idx_r + ONE_C;
          if (load_last) begin
            state_nxt = ST_MOVE;
          end
        end
      end

      ST_MOVE: begin
        ram_raddr = mv_src_r;
        if (mv_left_r != '0) begin
          mv_pend_nxt = 1'b1;
          mv_dst_nxt  = mv_up_r ? (mv_src_r + ONE_C) : (mv_src_r - mv_shift_r);
          mv_src_nxt  = mv_up_r ? (mv_src_r - ONE_C) : (mv_src_r + ONE_C);
          mv_left_nxt = mv_left_r - ONE_C;
        end else if (!mv_pend_r) begin
          if (ins_en_r) begin
            state_nxt = ST_INSERT;
          end else if (res_en_r) begin
            state_nxt = ST_RESULT;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end

      ST_INSERT: begin
        state_nxt = ST_RESULT;
      end

      ST_RESULT: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      mv_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      s1_v_r    <= scan_issue;
      s2_v_r    <= s1_v_r;
      mv_pend_r <= mv_pend_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r  <= op_t'(in_op);
      id_r  <= in_timer_id;
      dur_r <= in_duration;
      now_r <= in_now_time;
    end
    scan_idx_r   <= scan_idx_nxt;
    found_r      <= found_nxt;
    pos_r        <= pos_nxt;
    at_found_r   <= at_found_nxt;
    at_r         <= at_nxt;
    pop_stop_r   <= pop_stop_nxt;
    k_r          <= k_nxt;
    mv_src_r     <= mv_src_nxt;
    mv_left_r    <= mv_left_nxt;
    mv_up_r      <= mv_up_nxt;
    mv_shift_r   <= mv_shift_nxt;
    mv_dst_r     <= mv_dst_nxt;
    ins_en_r     <= ins_en_nxt;
    ins_r        <= ins_nxt;
    res_en_r     <= res_en_nxt;
    res_status_r <= res_status_nxt;
    res_id_r     <= res_id_nxt;
    emit_idx_r   <= emit_idx_nxt;
    // scan stages: slot index, then elapsed time
    s1_idx_r   <= scan_idx_r;
    s2_idx_r   <= s1_idx_r;
    el_r       <= now_r - rd_start;
    s2_dur_r   <= rd_dur;
    s2_match_r <= (rd_id == id_r);
    if (out_load) begin
      out_status_r <= load_status;
      out_id_r     <= load_id;
      out_last_r   <= load_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_expired_id = out_id_r;
  assign out_last       = out_last_r;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("queue count above depth");

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> !ram_we)
    else $error("slot write during scan");

  a_emit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (emit_idx_r < k_r))
    else $error("pop emission past pop count");

  a_move_dst_range: assert property (@(posedge clk) disable iff (!rst_n)
    mv_pend_r |-> (mv_dst_r < DEPTH_C))
    else $error("slot move outside queue");

  a_pops_in_queue: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DECIDE) |-> (k_r <= count_r))
    else $error("more pops than queued timers");
`endif

endmodule

// ----- hw/rtl/sdtq_ram.sv -----
module sdtq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- tb/tb_sorted_deadline_timer_queue.sv -----
`timescale 1ns / 100ps

module tb_sorted_deadline_timer_queue
  import sdtq_pkg::*;
();

  // shadow copy of the timer queue plus the results it still owes
  class deadline_scoreboard;

    typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ID_W-1:0]     tid;
      logic                last;
    } timer_result_t;

    logic [TIME_BITS_DEF-1:0] slot_t0  [DEPTH_DEF];
    logic [TIME_BITS_DEF-1:0] slot_len [DEPTH_DEF];
    logic [ID_W-1:0]          slot_tid [DEPTH_DEF];
    int                       n_queued;
    timer_result_t            due_results[$];
    int                       n_errors;

    function new();
      n_queued = 0;
      n_errors = 0;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    function void push_result(status_t st, logic [ID_W-1:0] tid, logic last);
      timer_result_t r;
      r.status = st;
      r.tid    = tid;
      r.last   = last;
      due_results.push_back(r);
    endfunction

    function int find_tid(logic [ID_W-1:0] tid);
      for (int i = 0; i < n_queued; i++)
        if (slot_tid[i] == tid) return i;
      return -1;
    endfunction

    function void remove_slot(int pos);
      for (int i = pos; i + 1 < n_queued; i++) begin
        slot_t0[i]  = slot_t0[i+1];
        slot_len[i] = slot_len[i+1];
        slot_tid[i] = slot_tid[i+1];
      end
      n_queued--;
    endfunction

    // queued timer fires strictly after a new one of length len started at t0
    function bit fires_later(int pos, logic [TIME_BITS_DEF-1:0] t0,
                             logic [TIME_BITS_DEF-1:0] len);
      logic [TIME_BITS_DEF-1:0] el;
      logic [TIME_BITS_DEF:0]   sum;
      el  = t0 - slot_t0[pos];
      sum = {1'b0, len} + {1'b0, el};
      if (sum[TIME_BITS_DEF]) return 1'b0;
      return slot_len[pos] > sum[TIME_BITS_DEF-1:0];
    endfunction

    // accepted input word: update the shadow queue, queue up its results
    function void note_word(op_t op, logic [ID_W-1:0] tid,
                            logic [TIME_BITS_DEF-1:0] len,
                            logic [TIME_BITS_DEF-1:0] now);
      int pos;
      int at;
      int popped;
      logic [TIME_BITS_DEF-1:0] el;
      pos = find_tid(tid);
      case (op)
        OP_START: begin
          if (pos >= 0) remove_slot(pos);
          if (n_queued >= DEPTH_DEF) begin
            push_result(STAT_FULL, tid, 1'b1);
          end else begin
            at = n_queued;
            for (int i = 0; i < n_queued; i++) begin
              if (fires_later(i, now, len)) begin
                at = i;
                break;
              end
            end
            for (int i = n_queued; i > at; i--) begin
              slot_t0[i]  = slot_t0[i-1];
              slot_len[i] = slot_len[i-1];
              slot_tid[i] = slot_tid[i-1];
            end
            slot_t0[at]  = now;
            slot_len[at] = len;
            slot_tid[at] = tid;
            n_queued++;
            push_result(STAT_STARTED, tid, 1'b1);
          end
        end
        OP_CANCEL: begin
          if (pos >= 0) begin
            remove_slot(pos);
            push_result(STAT_CANCELLED, tid, 1'b1);
          end else begin
            push_result(STAT_ABSENT, tid, 1'b1);
          end
        end
        default: begin
          // wake stops at the first live head, flush takes every head up to MAX_POPS
          popped = 0;
          while (n_queued > 0 && popped < MAX_POPS) begin
            el = now - slot_t0[0];
            if (op == OP_WAKE && el < slot_len[0]) break;
            push_result(STAT_EXPIRED, slot_tid[0], 1'b0);
            remove_slot(0);
            popped++;
          end
          if (popped == 0) push_result(STAT_NONE, '0, 1'b1);
          else due_results[due_results.size()-1].last = 1'b1;
        end
      endcase
    endfunction

    function void flag(string what);
      n_errors++;
      if (n_errors <= 10) $display("%t %s", $realtime, what);
    endfunction

    // accepted result word against the oldest one owed
    function void check_result(logic [STATUS_W-1:0] status, logic [ID_W-1:0] tid,
                               logic last);
      timer_result_t want;
      if (due_results.size() == 0) begin
        flag($sformatf("unexpected result: status %0d id %0d last %0d",
                       status, tid, last));
        return;
      end
      want = due_results.pop_front();
      if (want.status !== status || want.tid !== tid || want.last !== last)
        flag($sformatf({"mismatch: want status %0d id %0d last %0d,",
                        " got status %0d id %0d last %0d"},
                       want.status, want.tid, want.last, status, tid, last));
    endfunction

  endclass

  localparam int QUIET_LIMIT = 2000;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic [OP_W-1:0]          in_op;
  logic [ID_W-1:0]          in_timer_id;
  logic [TIME_BITS_DEF-1:0] in_duration;
  logic [TIME_BITS_DEF-1:0] in_now_time;
  logic                     out_valid;
  logic                     out_stall;
  logic [STATUS_W-1:0]      out_status;
  logic [ID_W-1:0]          out_expired_id;
  logic                     out_last;

  int                       idle_pct  = 0;
  int                       stall_pct = 0;
  int                       start_pct = 50;
  int                       quiet_cycles = 0;
  logic [TIME_BITS_DEF-1:0] wall;
  deadline_scoreboard       sb;

  sorted_deadline_timer_queue u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_timer_id    (in_timer_id),
    .in_duration    (in_duration),
    .in_now_time    (in_now_time),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_expired_id (out_expired_id),
    .out_last       (out_last)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // one input word, with a random gap in front of it
  task automatic send_word(op_t op, logic [ID_W-1:0] tid, logic [TIME_BITS_DEF-1:0] len,
                           logic [TIME_BITS_DEF-1:0] now);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid    <= 1'b1;
    in_op       <= op;
    in_timer_id <= tid;
    in_duration <= len;
    in_now_time <= now;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_word(op, tid, len, now);
  endtask

  // random word around a slowly moving clock, ids mostly from a small pool
  task automatic send_random();
    int unsigned pick;
    op_t op;
    logic [ID_W-1:0] tid;
    logic [TIME_BITS_DEF-1:0] len;
    logic [TIME_BITS_DEF-1:0] now;
    wall = wall + $urandom_range(3);
    if ($urandom_range(49) == 0) wall = $urandom;
    pick = $urandom_range(99);
    if (pick < start_pct) op = OP_START;
    else if (pick < start_pct + (100 - start_pct) / 3) op = OP_CANCEL;
    else if (pick < 96) op = OP_WAKE;
    else op = OP_FLUSH;
    tid = ($urandom_range(99) < 85) ? ID_W'($urandom_range(23)) : ID_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 70) len = $urandom_range(15);
    else if (pick < 85) len = $urandom_range(200);
    else if (pick < 95) len = $urandom;
    else len = pick[0] ? '1 : '0;
    now = ($urandom_range(9) == 0) ? wall - $urandom_range(20) : wall;
    send_word(op, tid, len, now);
  endtask

  // corner words: empty queue, extremes, restart, ties, full queue
  task automatic run_directed();
    send_word(OP_WAKE, '0, '0, '0);
    send_word(OP_CANCEL, '1, '1, '0);
    send_word(OP_START, 8'd0, '0, '0);
    send_word(OP_START, '1, '1, '1);
    send_word(OP_START, 8'd1, 32'd5, 32'd10);
    send_word(OP_START, 8'd1, 32'd3, 32'd11);
    send_word(OP_CANCEL, '1, '0, '1);
    send_word(OP_WAKE, '0, '0, 32'd14);
    for (int i = 0; i < DEPTH_DEF; i++)
      send_word(OP_START, ID_W'(16 + i), 32'd100, 32'd200);
    send_word(OP_START, 8'd99, 32'd1, 32'd201);
    send_word(OP_START, 8'd20, 32'd0, 32'd250);
    send_word(OP_FLUSH, '0, '0, '0);
  endtask

  // result side: check accepted words, stall at random
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_status, out_expired_id, out_last);
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[sorted_deadline_timer_queue] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    sb          = new();
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_op       = OP_START;
    in_timer_id = '0;
    in_duration = '0;
    in_now_time = '0;
    wall        = $urandom;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    run_directed();

    // random phases with different idle and stall mixes
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  start_pct = 50; end
        1: begin idle_pct = 47; stall_pct = 0;  start_pct = 80; end
        2: begin idle_pct = 0;  stall_pct = 47; start_pct = 50; end
        default: begin
          idle_pct = 9; stall_pct = 9; start_pct = 80;
          wall = 32'hFFFF_FF80;
        end
      endcase
      repeat (81) send_random();
    end
    in_valid <= 1'b0;

    // drain, then let any stray word show up
    while (sb.pending() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (sb.n_errors == 0 && sb.pending() == 0)
      $display("[sorted_deadline_timer_queue] OK");
    else
      $display("[sorted_deadline_timer_queue] ERROR");
    $finish;
  end

endmodule

// ----- sorted_deadline_timer_queue.f -----
hw/rtl/sdtq_pkg.sv
hw/rtl/sdtq_ram.sv
hw/rtl/sorted_deadline_timer_queue.sv
tb/tb_sorted_deadline_timer_queue.sv
